### hw/rtl/urbd_pkg.sv
// ----------------------------------------------------------------------------
// urbd_pkg
// Shared types and constants of the serial receive buffer device.
// ----------------------------------------------------------------------------
package urbd_pkg;

  // Receive buffer geometry
  localparam int unsigned BUF_DEPTH = 32;
  localparam int unsigned BUF_AW    = $clog2(BUF_DEPTH);
  localparam int unsigned CNT_W     = $clog2(BUF_DEPTH + 1);
  localparam logic [CNT_W-1:0] BUF_DEPTH_C = CNT_W'(BUF_DEPTH);

  // Device window
  localparam logic [31:0] RESET_BASE  = 32'h0200_2000;
  localparam logic [15:0] IDENT_LEN   = 16'd7;
  localparam logic [31:0] IDENT_WORDS = 32'd4;

  // Configuration register indexes (paddr[2])
  localparam logic REG_BASE_IDX = 1'b0;

  // Item kinds
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_PEEK  = 2'd1,
    OP_WRITE = 2'd2,
    OP_LOAD  = 2'd3
  } op_e;

  // Identity words, two characters each, high byte first
  function automatic logic [15:0] ident_word(logic [2:0] off);
    logic [15:0] w;
    case (off)
      3'd1:    w = 16'h5359;
      3'd2:    w = 16'h5355;
      3'd3:    w = 16'h4152;
      3'd4:    w = 16'h5400;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/uart_receive_buffer_device_core.sv
// ----------------------------------------------------------------------------
// uart_receive_buffer_device_core
// Memory-mapped serial device: identity header, receive buffer, transmit path.
// ----------------------------------------------------------------------------
//  channel   direction  content
//  s_axis    in         bus read / peek / write, or device-side load byte
//  m_axis    out        one result per item: read word, tx byte, irq flag
//  apb       in/out     base_address register at byte address 0
//
//  The buffer state is updated and the RAM is read at acceptance; the result
//  is formed from the registered RAM data as the item leaves the work stage.
//  Only one item is in the work stage at a time.
//  The output register lets the next item in while a result waits.
//  Reset is asynchronous; the buffer RAM itself is not cleared.
// ----------------------------------------------------------------------------
module uart_receive_buffer_device_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [47:0] s_axis_tdata_i,   // bus_address[31:0], data_word[47:32]
  input  logic        s_axis_tlast_i,   // load_last
  input  logic [2:0]  s_axis_tuser_i,   // op[1:0], load_empty[2]
  // result items
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // read_data[15:0], tx_byte[23:16]
  output logic [1:0]  m_axis_tuser_o,   // tx_valid[0], irq_request[1]
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned AW = urbd_pkg::BUF_AW;
  localparam int unsigned CW = urbd_pkg::CNT_W;

  // Configuration register
  logic [31:0] base_q;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == urbd_pkg::REG_BASE_IDX) ? base_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= urbd_pkg::RESET_BASE;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == urbd_pkg::REG_BASE_IDX) begin
      base_q <= pwdata;
    end
  end

  // Input decode
  urbd_pkg::op_e op;
  logic [31:0]   bus_addr;
  logic [15:0]   data_word;
  logic          load_last;
  logic          load_empty;

  assign op         = urbd_pkg::op_e'(s_axis_tuser_i[1:0]);
  assign load_empty = s_axis_tuser_i[2];
  assign bus_addr   = s_axis_tdata_i[31:0];
  assign data_word  = s_axis_tdata_i[47:32];
  assign load_last  = s_axis_tlast_i;

  // Buffer state
  logic [CW-1:0] read_idx_q, read_idx_d;
  logic [CW-1:0] valid_cnt_q, valid_cnt_d;
  logic [CW-1:0] load_idx_q, load_idx_d;
  logic          load_act_q, load_act_d;

  // Work stage and output register
  logic          stg_valid_q;
  logic          stg_mem_q, stg_mem_d;
  logic [15:0]   stg_rconst_q, stg_rconst_d;
  logic          stg_txv_q, stg_txv_d;
  logic [7:0]    stg_txb_q, stg_txb_d;
  logic          stg_irq_q, stg_irq_d;

  logic          out_valid_q;
  logic [15:0]   out_rdata_q;
  logic          out_txv_q;
  logic [7:0]    out_txb_q;
  logic          out_irq_q;

  logic          accept;
  logic          advance;

  assign s_axis_tready_o = !stg_valid_q;
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;
  assign advance = stg_valid_q && (!out_valid_q || m_axis_tready_i);

  // RAM ports
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  // Address window
  logic          in_win;
  logic [31:0]   offset;

  assign in_win = bus_addr >= base_q;
  assign offset = bus_addr - base_q;

  // Item processing: state update, RAM access, result preparation
  logic [CW-1:0] load_eff;
  logic          load_wr;
  logic [CW-1:0] load_next;

  always_comb begin
    read_idx_d   = read_idx_q;
    valid_cnt_d  = valid_cnt_q;
    load_idx_d   = load_idx_q;
    load_act_d   = load_act_q;
    stg_mem_d    = 1'b0;
    stg_rconst_d = 16'd0;
    stg_txv_d    = 1'b0;
    stg_txb_d    = 8'd0;
    stg_irq_d    = 1'b0;
    ram_re       = 1'b0;

    load_eff  = load_act_q ? load_idx_q : '0;
    load_wr   = accept && op == urbd_pkg::OP_LOAD && !load_empty &&
                load_eff < urbd_pkg::BUF_DEPTH_C;
    load_next = load_eff + CW'(load_wr);
    ram_we    = load_wr;
    ram_waddr = load_eff[AW-1:0];

    case (op)
      urbd_pkg::OP_LOAD: begin
        if (load_empty) begin
          valid_cnt_d = '0;
          read_idx_d  = '0;
          load_idx_d  = '0;
          load_act_d  = 1'b0;
          stg_irq_d   = 1'b1;
        end else if (load_last) begin
          valid_cnt_d = load_next;
          read_idx_d  = '0;
          load_idx_d  = '0;
          load_act_d  = 1'b0;
          stg_irq_d   = 1'b1;
        end else begin
          load_idx_d  = load_next;
          load_act_d  = 1'b1;
        end
      end
      urbd_pkg::OP_WRITE: begin
        if (in_win && offset > urbd_pkg::IDENT_WORDS) begin
          stg_txv_d = 1'b1;
          stg_txb_d = data_word[7:0];
        end
      end
      urbd_pkg::OP_READ, urbd_pkg::OP_PEEK: begin
        if (!in_win) begin
          stg_rconst_d = 16'd0;
        end else if (offset == 32'd0) begin
          stg_rconst_d = urbd_pkg::IDENT_LEN;
        end else if (offset <= urbd_pkg::IDENT_WORDS) begin
          stg_rconst_d = urbd_pkg::ident_word(offset[2:0]);
        end else if (read_idx_q < valid_cnt_q &&
                     read_idx_q < urbd_pkg::BUF_DEPTH_C) begin
          stg_mem_d = 1'b1;
          ram_re    = accept;
          if (op == urbd_pkg::OP_READ) begin
            read_idx_d = read_idx_q + CW'(1);
          end
        end
      end
      default: begin
        stg_rconst_d = 16'd0;
      end
    endcase
  end

  urbd_ram #(
    .Depth (urbd_pkg::BUF_DEPTH),
    .Width (8)
  ) u_rx_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (data_word[7:0]),
    .re_i    (ram_re),
    .raddr_i (read_idx_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_idx_q  <= '0;
      valid_cnt_q <= '0;
      load_idx_q  <= '0;
      load_act_q  <= 1'b0;
      stg_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        read_idx_q  <= read_idx_d;
        valid_cnt_q <= valid_cnt_d;
        load_idx_q  <= load_idx_d;
        load_act_q  <= load_act_d;
      end
      if (accept) begin
        stg_valid_q <= 1'b1;
      end else if (advance) begin
        stg_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_mem_q    <= stg_mem_d;
      stg_rconst_q <= stg_rconst_d;
      stg_txv_q    <= stg_txv_d;
      stg_txb_q    <= stg_txb_d;
      stg_irq_q    <= stg_irq_d;
    end
    if (advance) begin
      out_rdata_q <= stg_mem_q ? {8'd0, ram_rdata} : stg_rconst_q;
      out_txv_q   <= stg_txv_q;
      out_txb_q   <= stg_txb_q;
      out_irq_q   <= stg_irq_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_txb_q, out_rdata_q};
  assign m_axis_tuser_o  = {out_irq_q, out_txv_q};

  // Checks
  a_read_le_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    read_idx_q <= valid_cnt_q)
    else $error("read index passed fill count");

  a_count_le_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_cnt_q <= urbd_pkg::BUF_DEPTH_C && load_idx_q <= urbd_pkg::BUF_DEPTH_C)
    else $error("buffer count beyond depth");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !s_axis_tready_o)
    else $error("item accepted while work stage busy");

  a_tx_irq_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_txv_q && out_irq_q))
    else $error("tx and irq in one result");

  a_no_rd_on_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("RAM read and write in one cycle");

endmodule

### hw/rtl/urbd_ram.sv
// ----------------------------------------------------------------------------
// urbd_ram
// Single-port-write, single-port-read synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module urbd_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
